// ===== sv/dtlf_pkg.sv =====
`default_nettype none

package dtlf_pkg;

    localparam int HANDLE_FW = 16;

    typedef enum logic [2:0] {
        OP_OPEN    = 3'd0,
        OP_CLOSE   = 3'd1,
        OP_OPEN_AT = 3'd2,
        OP_GET     = 3'd3,
        OP_CLEAR   = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_BADF  = 2'd2,
        STAT_INVAL = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]           opcode;
        logic [7:0]           slot_index;
        logic [HANDLE_FW-1:0] object_handle;
    } req_t;

    typedef struct packed {
        status_t              status;
        logic [5:0]           result_index;
        logic [HANDLE_FW-1:0] result_handle;
    } rsp_t;

endpackage

`default_nettype wire

// ===== sv/dtlf_ram.sv =====
`default_nettype none

module dtlf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/dtlf_free_finder.sv =====
`default_nettype none

// Lowest free slot, two registered levels: groups of eight, then across groups.
// The output follows the valid bits through the group registers, then the output registers.
module dtlf_free_finder #(
    parameter int MAX_FD = 64
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [MAX_FD-1:0]         taken,
    output logic                           free_any,
    output logic [$clog2(MAX_FD)-1:0]      free_idx
);

    localparam int IDX_W = $clog2(MAX_FD);
    localparam int NG    = (MAX_FD + 7) / 8;
    localparam int PW    = $clog2(NG * 8);

    logic [NG*8-1:0] taken_pad;
    logic [NG-1:0]   grp_free_next;
    logic [2:0]      grp_off_next [NG];
    logic [NG-1:0]   grp_free_reg;
    logic [2:0]      grp_off_reg [NG];
    logic            free_any_next;
    logic [PW-1:0]   sel_next;
    logic            free_any_reg;
    logic [IDX_W-1:0] free_idx_reg;

    always_comb
    begin
        taken_pad = '1;
        taken_pad[MAX_FD-1:0] = taken;
        for (int g = 0; g < NG; g++)
        begin
            grp_free_next[g] = ~&taken_pad[g*8 +: 8];
            grp_off_next[g]  = 3'd0;
            for (int b = 7; b >= 0; b--)
            begin
                if (!taken_pad[g*8 + b])
                begin
                    grp_off_next[g] = 3'(b);
                end
            end
        end
    end

    always_comb
    begin
        free_any_next = |grp_free_reg;
        sel_next = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (grp_free_reg[g])
            begin
                sel_next = PW'(g * 8) | PW'(grp_off_reg[g]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_free_reg <= '0;
            free_any_reg <= 1'b0;
            free_idx_reg <= '0;
            for (int g = 0; g < NG; g++)
            begin
                grp_off_reg[g] <= 3'd0;
            end
        end
        else
        begin
            grp_free_reg <= grp_free_next;
            free_any_reg <= free_any_next;
            free_idx_reg <= IDX_W'(sel_next);
            for (int g = 0; g < NG; g++)
            begin
                grp_off_reg[g] <= grp_off_next[g];
            end
        end
    end

    assign free_any = free_any_reg;
    assign free_idx = free_idx_reg;

endmodule

`default_nettype wire

// ===== sv/descriptor_table_lowest_free.sv =====
// A request is taken in S_IDLE only, then waits in S_SETTLE while the lowest-free search
// settles after the last slot update. Open, open-at, clear and rejected requests get a
// registered result from S_EXEC; close and get read the handle RAM, answer from S_READ.
// Both states wait while rsp_stall holds the output; a new request waits for the result.
// Reset: every slot free at once (valid flops cleared); handle RAM contents undefined.
`default_nettype none

module descriptor_table_lowest_free #(
    parameter int MAX_FD   = 64,
    parameter int HANDLE_W = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire dtlf_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output dtlf_pkg::rsp_t     rsp
);

    localparam int IDX_W = $clog2(MAX_FD);
    localparam int ST_W  = (HANDLE_W < dtlf_pkg::HANDLE_FW) ? HANDLE_W : dtlf_pkg::HANDLE_FW;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETTLE,
        S_EXEC,
        S_READ
    } state_t;

    state_t               state_reg, state_next;
    dtlf_pkg::req_t       req_reg, req_next;
    logic [(1<<IDX_W)-1:0] valid_reg, valid_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    dtlf_pkg::rsp_t       rsp_reg, rsp_next;

    logic             free_any;
    logic [IDX_W-1:0] free_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ST_W-1:0]  wr_data;
    logic             rd_en;
    logic [ST_W-1:0]  rd_data;

    logic [IDX_W-1:0] idx;
    logic             in_range;
    logic             taken;
    logic             out_free;

    dtlf_free_finder #(
        .MAX_FD (MAX_FD)
    ) u_finder (
        .clk      (clk),
        .rst_n    (rst_n),
        .taken    (valid_reg[MAX_FD-1:0]),
        .free_any (free_any),
        .free_idx (free_idx)
    );

    dtlf_ram #(
        .WIDTH (ST_W),
        .DEPTH (MAX_FD)
    ) u_handles (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx),
        .rd_data (rd_data)
    );

    assign idx      = req_reg.slot_index[IDX_W-1:0];
    assign in_range = {1'b0, req_reg.slot_index} < 9'(MAX_FD);
    assign taken    = in_range && valid_reg[idx];
    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        valid_next     = valid_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_addr        = idx;
        wr_data        = req_reg.object_handle[ST_W-1:0];
        rd_en          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = S_SETTLE;
                end
            end
            S_SETTLE:
            begin
                // free finder catches up with the previous update
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    rsp_next       = '{status: dtlf_pkg::STAT_OK, result_index: '0,
                                       result_handle: '0};
                    unique case (req_reg.opcode)
                        dtlf_pkg::OP_OPEN:
                        begin
                            if (free_any)
                            begin
                                wr_en                 = 1'b1;
                                wr_addr               = free_idx;
                                valid_next[free_idx]  = 1'b1;
                                rsp_next.result_index = 6'(free_idx);
                            end
                            else
                            begin
                                rsp_next.status = dtlf_pkg::STAT_FULL;
                            end
                        end
                        dtlf_pkg::OP_CLOSE,
                        dtlf_pkg::OP_GET:
                        begin
                            if (taken)
                            begin
                                rd_en          = 1'b1;
                                rsp_valid_next = 1'b0;
                                state_next     = S_READ;
                                if (req_reg.opcode == dtlf_pkg::OP_CLOSE)
                                begin
                                    valid_next[idx] = 1'b0;
                                end
                            end
                            else
                            begin
                                rsp_next.status = dtlf_pkg::STAT_BADF;
                            end
                        end
                        dtlf_pkg::OP_OPEN_AT:
                        begin
                            if (!in_range)
                            begin
                                rsp_next.status = dtlf_pkg::STAT_INVAL;
                            end
                            else if (taken)
                            begin
                                rsp_next.status = dtlf_pkg::STAT_FULL;
                            end
                            else
                            begin
                                wr_en                 = 1'b1;
                                valid_next[idx]       = 1'b1;
                                rsp_next.result_index = 6'(idx);
                            end
                        end
                        dtlf_pkg::OP_CLEAR:
                        begin
                            valid_next = '0;
                        end
                        default:
                        begin
                            rsp_next.status = dtlf_pkg::STAT_INVAL;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                // rd_data holds until the next read, so waiting on the output is safe
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    rsp_next       = '{status: dtlf_pkg::STAT_OK, result_index: '0,
                                       result_handle: dtlf_pkg::HANDLE_FW'(rd_data)};
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_reg       <= '0;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            valid_reg     <= valid_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire
